// ===== hdl/fsw_pkg.sv =====
`timescale 1ns / 1ps

package fsw_pkg;

    localparam int COUNTER_WIDTH  = 16;
    localparam int FREQ_WIDTH     = 20;
    localparam int HALF_WIDTH     = COUNTER_WIDTH - 1;
    localparam int PRESCALE_WIDTH = 10;
    localparam int DIVIDEND_WIDTH = 26;
    localparam int STEP_WIDTH     = $clog2(DIVIDEND_WIDTH);

    localparam logic [DIVIDEND_WIDTH-1:0] REF_SLOW = DIVIDEND_WIDTH'(50000);
    localparam logic [DIVIDEND_WIDTH-1:0] REF_MID  = DIVIDEND_WIDTH'(6000000);
    localparam logic [DIVIDEND_WIDTH-1:0] REF_FAST = DIVIDEND_WIDTH'(48000000);

    localparam logic [PRESCALE_WIDTH-1:0] DIV_SLOW_M1 = PRESCALE_WIDTH'(960 - 1);
    localparam logic [PRESCALE_WIDTH-1:0] DIV_MID_M1  = PRESCALE_WIDTH'(8 - 1);

    localparam logic [FREQ_WIDTH-1:0] LIMIT_SLOW = FREQ_WIDTH'(100);
    localparam logic [FREQ_WIDTH-1:0] LIMIT_MID  = FREQ_WIDTH'(1000);

    localparam logic [STEP_WIDTH-1:0] DIV_LAST_STEP = STEP_WIDTH'(DIVIDEND_WIDTH - 1);

    typedef enum logic [1:0] {
        PSEL_DIV1   = 2'd0,
        PSEL_DIV8   = 2'd1,
        PSEL_DIV960 = 2'd2,
        PSEL_UNUSED = 2'd3
    } psel_t;

    // controller -> datapath
    typedef struct packed {
        logic tick;
        logic stop;
        logic div_start;
        logic div_step;
        logic setup_load;
        logic out_load;
    } fsw_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic freq_zero;
        logic div_last;
    } fsw_status_t;

endpackage

// ===== hdl/fsw_datapath.sv =====
`timescale 1ns / 1ps

module fsw_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [fsw_pkg::FREQ_WIDTH-1:0] cfg_wr_data,
    input  fsw_pkg::fsw_cmd_t             cmd,
    output fsw_pkg::fsw_status_t          status,
    output logic                          out_level,
    output logic                          out_period_end
);
    import fsw_pkg::*;

    logic [FREQ_WIDTH-1:0]     target_freq_reg;
    logic [PRESCALE_WIDTH-1:0] prescale_count_reg, prescale_count_next;
    logic [COUNTER_WIDTH-1:0]  period_count_reg, period_count_next;
    logic [COUNTER_WIDTH-1:0]  period_base_reg, period_base_next;
    logic [HALF_WIDTH-1:0]     half_period_reg, half_period_next;
    logic [FREQ_WIDTH-1:0]     frac_rem_reg, frac_rem_next;
    logic [FREQ_WIDTH-1:0]     cycle_phase_reg, cycle_phase_next;
    psel_t                     psel_reg, psel_next;
    logic                      running_reg, running_next;

    logic [FREQ_WIDTH-1:0]     div_freq_reg, div_freq_next;
    logic [FREQ_WIDTH-1:0]     div_rem_reg, div_rem_next;
    logic [DIVIDEND_WIDTH-1:0] div_quo_reg, div_quo_next;
    logic [STEP_WIDTH-1:0]     div_count_reg, div_count_next;

    logic out_level_reg, out_level_next;
    logic out_end_reg, out_end_next;

    logic [FREQ_WIDTH:0]       trial;
    logic [FREQ_WIDTH:0]       trial_diff;
    logic [COUNTER_WIDTH-1:0]  quo_sat;
    logic [FREQ_WIDTH-1:0]     phase_inc;

    function automatic logic [COUNTER_WIDTH-1:0] load_value(
        input logic [COUNTER_WIDTH-1:0] base,
        input logic [FREQ_WIDTH-1:0]    phase,
        input logic [FREQ_WIDTH-1:0]    frac
    );
        logic [COUNTER_WIDTH:0] len;
        len = {1'b0, base} + {{COUNTER_WIDTH{1'b0}}, (phase < frac)};
        return COUNTER_WIDTH'(len - 1'b1);
    endfunction

    function automatic logic [PRESCALE_WIDTH-1:0] prescale_last(input psel_t sel);
        logic [PRESCALE_WIDTH-1:0] last;
        case (sel)
            PSEL_DIV960: last = DIV_SLOW_M1;
            PSEL_DIV8:   last = DIV_MID_M1;
            default:     last = '0;
        endcase
        return last;
    endfunction

    assign status.freq_zero = (target_freq_reg == '0);
    assign status.div_last  = (div_count_reg == '0);

    assign trial      = {div_rem_reg, div_quo_reg[DIVIDEND_WIDTH-1]};
    assign trial_diff = trial - {1'b0, div_freq_reg};
    assign quo_sat    = (|div_quo_reg[DIVIDEND_WIDTH-1:COUNTER_WIDTH]) ? '1 :
                        (div_quo_reg[COUNTER_WIDTH-1:0] == '0) ? COUNTER_WIDTH'(1) :
                        div_quo_reg[COUNTER_WIDTH-1:0];
    assign phase_inc  = cycle_phase_reg + 1'b1;

    always_comb begin
        prescale_count_next = prescale_count_reg;
        period_count_next   = period_count_reg;
        period_base_next    = period_base_reg;
        half_period_next    = half_period_reg;
        frac_rem_next       = frac_rem_reg;
        cycle_phase_next    = cycle_phase_reg;
        psel_next           = psel_reg;
        running_next        = running_reg;
        div_freq_next       = div_freq_reg;
        div_rem_next        = div_rem_reg;
        div_quo_next        = div_quo_reg;
        div_count_next      = div_count_reg;
        out_level_next      = out_level_reg;
        out_end_next        = out_end_reg;

        if (cmd.tick) begin
            out_end_next = 1'b0;
            if (!running_reg) begin
                out_level_next = 1'b1;
            end else begin
                out_level_next = (period_count_reg <= {1'b0, half_period_reg});
                if (prescale_count_reg >= prescale_last(psel_reg)) begin
                    prescale_count_next = '0;
                    if (period_count_reg == '0) begin
                        cycle_phase_next  = (phase_inc >= target_freq_reg) ? '0 : phase_inc;
                        period_count_next = load_value(period_base_reg, cycle_phase_next,
                                                       frac_rem_reg);
                        out_end_next      = 1'b1;
                    end else begin
                        period_count_next = period_count_reg - 1'b1;
                    end
                end else begin
                    prescale_count_next = prescale_count_reg + 1'b1;
                end
            end
        end

        if (cmd.stop) begin
            running_next        = 1'b0;
            prescale_count_next = '0;
            cycle_phase_next    = '0;
            period_count_next   = '0;
            period_base_next    = '0;
            half_period_next    = '0;
            frac_rem_next       = '0;
            psel_next           = PSEL_DIV1;
            out_level_next      = 1'b1;
            out_end_next        = 1'b0;
        end

        if (cmd.div_start) begin
            div_freq_next  = target_freq_reg;
            div_rem_next   = '0;
            div_count_next = DIV_LAST_STEP;
            if (target_freq_reg < LIMIT_SLOW) begin
                div_quo_next = REF_SLOW;
                psel_next    = PSEL_DIV960;
            end else if (target_freq_reg <= LIMIT_MID) begin
                div_quo_next = REF_MID;
                psel_next    = PSEL_DIV8;
            end else begin
                div_quo_next = REF_FAST;
                psel_next    = PSEL_DIV1;
            end
        end

        if (cmd.div_step) begin
            if (!trial_diff[FREQ_WIDTH]) begin
                div_rem_next = trial_diff[FREQ_WIDTH-1:0];
            end else begin
                div_rem_next = trial[FREQ_WIDTH-1:0];
            end
            div_quo_next   = {div_quo_reg[DIVIDEND_WIDTH-2:0], !trial_diff[FREQ_WIDTH]};
            div_count_next = div_count_reg - 1'b1;
        end

        if (cmd.setup_load) begin
            running_next        = 1'b1;
            prescale_count_next = '0;
            cycle_phase_next    = '0;
            period_base_next    = quo_sat;
            half_period_next    = quo_sat[COUNTER_WIDTH-1:1];
            frac_rem_next       = div_rem_reg;
            period_count_next   = load_value(quo_sat, '0, div_rem_reg);
            out_level_next      = (period_count_next <= {1'b0, half_period_next});
            out_end_next        = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_freq_reg    <= '0;
            prescale_count_reg <= '0;
            period_count_reg   <= '0;
            period_base_reg    <= '0;
            half_period_reg    <= '0;
            frac_rem_reg       <= '0;
            cycle_phase_reg    <= '0;
            psel_reg           <= PSEL_DIV1;
            running_reg        <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                target_freq_reg <= cfg_wr_data;
            end
            prescale_count_reg <= prescale_count_next;
            period_count_reg   <= period_count_next;
            period_base_reg    <= period_base_next;
            half_period_reg    <= half_period_next;
            frac_rem_reg       <= frac_rem_next;
            cycle_phase_reg    <= cycle_phase_next;
            psel_reg           <= psel_next;
            running_reg        <= running_next;
        end
    end

    always_ff @(posedge aclk) begin
        div_freq_reg  <= div_freq_next;
        div_rem_reg   <= div_rem_next;
        div_quo_reg   <= div_quo_next;
        div_count_reg <= div_count_next;
        if (cmd.out_load) begin
            out_level_reg <= out_level_next;
            out_end_reg   <= out_end_next;
        end
    end

    assign out_level      = out_level_reg;
    assign out_period_end = out_end_reg;

endmodule

// ===== hdl/fsw_controller.sv =====
`timescale 1ns / 1ps

module fsw_controller (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_restart,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  fsw_pkg::fsw_status_t status,
    output fsw_pkg::fsw_cmd_t    cmd
);
    import fsw_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIV    = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;
    logic   accept;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!s_restart) begin
                        cmd.tick     = 1'b1;
                        cmd.out_load = 1'b1;
                    end else if (status.freq_zero) begin
                        cmd.stop     = 1'b1;
                        cmd.out_load = 1'b1;
                    end else begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.setup_load = 1'b1;
                    cmd.out_load   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== hdl/fractional_square_wave_generator.sv =====
`timescale 1ns / 1ps
// Tick transaction: result registered in the cycle after acceptance, one tick per cycle
// when the output is not stalled. Restart transaction, nonzero frequency: 26-step restoring
// divider (one quotient bit per cycle), then a load step waiting for a free output; no input
// taken meanwhile. Zero-frequency restart: stops the block, result in the next cycle.
// Synchronous active-low reset: stopped, outputs high on ticks, frequency register zero.

module fractional_square_wave_generator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [fsw_pkg::FREQ_WIDTH-1:0] cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_restart,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_mod_level,
    output logic                          m_rf_enable_level,
    output logic                          m_period_end
);
    import fsw_pkg::*;

    fsw_cmd_t    cmd;
    fsw_status_t status;
    logic        level;

    fsw_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_restart(s_restart),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .status   (status),
        .cmd      (cmd)
    );

    fsw_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .cmd           (cmd),
        .status        (status),
        .out_level     (level),
        .out_period_end(m_period_end)
    );

    assign m_mod_level       = level;
    assign m_rf_enable_level = level;

    a_tick_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_restart) |=> m_valid)
        else $error("tick transaction produced no result");

    a_restart_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_restart && !status.freq_zero) |=> (!s_ready && !m_valid))
        else $error("input taken or result shown during divide");

    a_end_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_period_end) |-> m_mod_level)
        else $error("period end with low level");

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({cmd.tick, cmd.stop, cmd.div_start, cmd.div_step, cmd.setup_load}) <= 1)
        else $error("conflicting datapath commands");

endmodule
